[rtl/core/cto_pkg.sv]
// ----------------------------------------------------------------------------
// cto_pkg
// Shared types and constants for the connection timeout table.
// ----------------------------------------------------------------------------
package cto_pkg;

  localparam int ACTION_W  = 2;
  localparam int ID_W      = 6;
  localparam int NOW_W     = 32;
  localparam int TIMEOUT_W = 16;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd60;

  localparam logic [ACTION_W-1:0] ACT_ADD     = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_REFRESH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_CHECK   = 2'd3;

  // Per-cycle control broadcast to every cell of the row.
  typedef struct packed {
    logic            upd_add;      // add on upd_id
    logic            upd_refresh;  // refresh on upd_id if live
    logic            upd_remove;   // remove upd_id
    logic [ID_W-1:0] upd_id;
    logic            chk_load;     // latch expired flags, seed ring
    logic            chk_step;     // compare against ring entry, shift ring
    logic            emit_take;    // selected cell is reported and cleared
  } cto_ctrl_t;

endpackage

[rtl/core/cto_if.sv]
// ----------------------------------------------------------------------------
// cto_in_if / cto_out_if
// Valid/ready channels for table commands and expired-slot reports.
// ----------------------------------------------------------------------------
interface cto_in_if;
  logic                         valid;
  logic                         ready;
  logic [cto_pkg::ACTION_W-1:0] action;
  logic [cto_pkg::ID_W-1:0]     conn_id;
  logic [cto_pkg::NOW_W-1:0]    now_seconds;

  modport source (output valid, output action, output conn_id, output now_seconds,
                  input ready);
  modport sink   (input valid, input action, input conn_id, input now_seconds,
                  output ready);
endinterface

interface cto_out_if;
  logic                     valid;
  logic                     ready;
  logic [cto_pkg::ID_W-1:0] expired_id;
  logic                     last;

  modport source (output valid, output expired_id, output last, input ready);
  modport sink   (input valid, input expired_id, input last, output ready);
endinterface

[rtl/core/cto_cell.sv]
// ----------------------------------------------------------------------------
// cto_cell
// One connection slot: live bit, expiry, and one stage of the rank ring.
// ----------------------------------------------------------------------------
module cto_cell #(
  parameter int CELL_ID   = 0,
  parameter int TIME_BITS = 32,
  parameter int IDW       = 6,
  parameter int CW        = 7
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cto_pkg::cto_ctrl_t  ctrl,
  input  logic [TIME_BITS-1:0] now_t,
  input  logic [TIME_BITS-1:0] new_exp,
  input  logic [CW-1:0]        emit_rank,
  input  logic [TIME_BITS-1:0] ring_exp_in,
  input  logic                 ring_flag_in,
  input  logic [IDW-1:0]       ring_id_in,
  output logic [TIME_BITS-1:0] ring_exp_out,
  output logic                 ring_flag_out,
  output logic [IDW-1:0]       ring_id_out,
  output logic                 sel
);
  import cto_pkg::*;

  logic                 live_r, live_nxt;
  logic [TIME_BITS-1:0] exp_r, exp_nxt;
  logic                 hit_r, hit_nxt;
  logic [CW-1:0]        rank_r, rank_nxt;
  logic [TIME_BITS-1:0] c_exp_r;
  logic                 c_flag_r;
  logic [IDW-1:0]       c_id_r;
  logic                 id_match;
  logic                 ahead;

  assign id_match = (ctrl.upd_id == ID_W'(CELL_ID));
  // passing entry sorts before this one
  assign ahead = (c_exp_r < exp_r) || ((c_exp_r == exp_r) && (c_id_r < IDW'(CELL_ID)));
  assign sel   = hit_r && (rank_r == emit_rank);

  always_comb begin
    live_nxt = live_r;
    exp_nxt  = exp_r;
    hit_nxt  = hit_r;
    rank_nxt = rank_r;
    if (id_match && ctrl.upd_add) begin
      live_nxt = 1'b1;
      exp_nxt  = new_exp;
    end
    if (id_match && ctrl.upd_refresh && live_r) begin
      exp_nxt = new_exp;
    end
    if (id_match && ctrl.upd_remove) begin
      live_nxt = 1'b0;
    end
    if (ctrl.chk_load) begin
      hit_nxt  = live_r && (exp_r <= now_t);
      rank_nxt = '0;
    end
    if (ctrl.chk_step && c_flag_r && hit_r && ahead) begin
      rank_nxt = rank_r + CW'(1);
    end
    if (ctrl.emit_take && sel) begin
      live_nxt = 1'b0;
      hit_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
      hit_r  <= 1'b0;
      rank_r <= '0;
    end else begin
      live_r <= live_nxt;
      hit_r  <= hit_nxt;
      rank_r <= rank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
    if (ctrl.chk_load) begin
      c_exp_r  <= exp_r;
      c_flag_r <= live_r && (exp_r <= now_t);
      c_id_r   <= IDW'(CELL_ID);
    end else if (ctrl.chk_step) begin
      c_exp_r  <= ring_exp_in;
      c_flag_r <= ring_flag_in;
      c_id_r   <= ring_id_in;
    end
  end

  assign ring_exp_out  = c_exp_r;
  assign ring_flag_out = c_flag_r;
  assign ring_id_out   = c_id_r;

endmodule

[rtl/core/connection_timeout_table.sv]
// ----------------------------------------------------------------------------
// connection_timeout_table
// Per-connection idle expiry table with ordered reporting of expired slots.
// ----------------------------------------------------------------------------
// Add, refresh and remove leave the block ready again on the next cycle. A
// check first ranks the expired slots and then reports them. The ranking is
// done by the ring of slot cells: every cell's entry travels once around the
// ring, one hop per cycle, and each cell counts how many expired entries sort
// before its own (earlier expiry, then lower slot). Reports then leave in rank
// order, back to back unless the output stalls; each reported slot is cleared,
// and the final one carries last. A check that finds nothing expired yields no
// transaction. Expiry is now plus the programmed timeout, saturating at the top
// of the TIME_BITS range; now_seconds is taken modulo 2^TIME_BITS. cfg_wdata is
// written when cfg_we is high; the user must write it only while the block is
// idle, which the block itself does not enforce. The input is accepted only
// between checks; updates never stall.
// ----------------------------------------------------------------------------
module connection_timeout_table #(
  parameter int CONNECTIONS = 64,
  parameter int TIME_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cto_pkg::TIMEOUT_W-1:0] cfg_wdata,
  cto_in_if.sink                        in_ch,
  cto_out_if.source                     out_ch
);
  import cto_pkg::*;

  localparam int IDW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int CW  = $clog2(CONNECTIONS + 1);
  localparam int SW  = ((TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W) + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RANK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]           state_r, state_nxt;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic [CW-1:0]        step_r, step_nxt;
  logic [CW-1:0]        hits_r, hits_nxt;
  logic [CW-1:0]        emit_k_r, emit_k_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]      out_id_r;
  logic                 out_last_r;
  logic                 out_load;

  logic                 in_fire;
  logic [63:0]          now_w;
  logic [TIME_BITS-1:0] now_t;
  logic [SW-1:0]        exp_sum;
  logic [TIME_BITS-1:0] new_exp;
  cto_ctrl_t            ctrl;

  logic [TIME_BITS-1:0] ring_exp  [CONNECTIONS];
  logic                 ring_flag [CONNECTIONS];
  logic [IDW-1:0]       ring_id   [CONNECTIONS];
  logic [CONNECTIONS-1:0] sel;
  logic [IDW-1:0]       sel_idx;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // time masked to TIME_BITS; expiry saturates at all ones
  assign now_w   = 64'(in_ch.now_seconds);
  assign now_t   = now_w[TIME_BITS-1:0];
  assign exp_sum = SW'(now_t) + SW'(timeout_r);
  assign new_exp = (exp_sum > SW'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                      : exp_sum[TIME_BITS-1:0];

  always_comb begin
    ctrl             = '0;
    ctrl.upd_id      = in_ch.conn_id;
    ctrl.upd_add     = in_fire && (in_ch.action == ACT_ADD);
    ctrl.upd_refresh = in_fire && (in_ch.action == ACT_REFRESH);
    ctrl.upd_remove  = in_fire && (in_ch.action == ACT_REMOVE);
    ctrl.chk_load    = in_fire && (in_ch.action == ACT_CHECK);
    ctrl.chk_step    = (state_r == ST_RANK);
    ctrl.emit_take   = out_load;
  end

  // slot cells; ring entries move from cell i+1 to cell i
  for (genvar g = 0; g < CONNECTIONS; g++) begin : g_cell
    cto_cell #(
      .CELL_ID  (g),
      .TIME_BITS(TIME_BITS),
      .IDW      (IDW),
      .CW       (CW)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .now_t        (now_t),
      .new_exp      (new_exp),
      .emit_rank    (emit_k_r),
      .ring_exp_in  (ring_exp[(g + 1) % CONNECTIONS]),
      .ring_flag_in (ring_flag[(g + 1) % CONNECTIONS]),
      .ring_id_in   (ring_id[(g + 1) % CONNECTIONS]),
      .ring_exp_out (ring_exp[g]),
      .ring_flag_out(ring_flag[g]),
      .ring_id_out  (ring_id[g]),
      .sel          (sel[g])
    );
  end

  // at most one cell matches the current rank
  always_comb begin
    sel_idx = '0;
    for (int i = 0; i < CONNECTIONS; i++) begin
      if (sel[i]) begin
        sel_idx = sel_idx | IDW'(i);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    hits_nxt      = hits_r;
    emit_k_nxt    = emit_k_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (ctrl.chk_load) begin
          state_nxt = ST_RANK;
          step_nxt  = '0;
          hits_nxt  = '0;
        end
      end
      ST_RANK: begin
        // every entry passes cell 0 once: count expired entries there
        hits_nxt = hits_r + CW'(ring_flag[0]);
        step_nxt = step_r + CW'(1);
        if (step_r == CW'(CONNECTIONS - 1)) begin
          state_nxt  = ST_EMIT;
          emit_k_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (emit_k_r == hits_r) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          emit_k_nxt    = emit_k_r + CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      hits_r      <= '0;
      emit_k_r    <= '0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      hits_r      <= hits_nxt;
      emit_k_r    <= emit_k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id_r   <= ID_W'(sel_idx);
      out_last_r <= ((emit_k_r + CW'(1)) == hits_r);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.expired_id = out_id_r;
  assign out_ch.last       = out_last_r;

endmodule

[rtl/core/cto_checker.sv]
// ----------------------------------------------------------------------------
// cto_checker
// Port-level checks on the connection timeout table.
// ----------------------------------------------------------------------------
module cto_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [cto_pkg::ACTION_W-1:0] in_action,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [cto_pkg::ID_W-1:0]     out_expired_id,
  input logic                         out_last
);
  import cto_pkg::*;

  // a stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_expired_id) && $stable(out_last))
    else $error("stalled report changed");

  // a check blocks further commands
  a_check_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == ACT_CHECK) |=> !in_ready)
    else $error("ready after check accepted");

  // updates leave the input ready on the next cycle
  a_update_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action != ACT_CHECK) |=> in_ready)
    else $error("update stalled input");

  // more reports follow a report without last
  a_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> !in_ready)
    else $error("check ended before last report");

  // no report straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("report valid after reset");

endmodule

bind connection_timeout_table cto_checker u_cto_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_action     (in_ch.action),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_expired_id(out_ch.expired_id),
  .out_last      (out_ch.last)
);
